// File: rtl/mxn_pkg.sv
// Shared types and codes of the mutual exclusion node.
package mxn_pkg;

    localparam int FifoDepth = 16;
    localparam int FifoCap   = 15;
    localparam int PtrW      = 4;
    localparam int FillW     = 5;
    localparam int IdW       = 4;
    localparam int StampW    = 16;

    localparam logic [1:0] M_LREQ   = 2'd0;
    localparam logic [1:0] M_LEXIT  = 2'd1;
    localparam logic [1:0] M_RREQ   = 2'd2;
    localparam logic [1:0] M_RGRANT = 2'd3;

    localparam logic [2:0] OP_LREQ   = 3'd0;
    localparam logic [2:0] OP_LEXIT  = 3'd1;
    localparam logic [2:0] OP_RREQ   = 3'd2;
    localparam logic [2:0] OP_RGRANT = 3'd3;
    localparam logic [2:0] OP_BAD    = 3'd4;

    localparam logic [2:0] K_STATUS = 3'd0;
    localparam logic [2:0] K_GRANT  = 3'd1;
    localparam logic [2:0] K_BCAST  = 3'd2;
    localparam logic [2:0] K_ENTER  = 3'd3;
    localparam logic [2:0] K_REJECT = 3'd4;
    localparam logic [2:0] K_DROP   = 3'd5;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_CS   = 2'd2;

    typedef struct packed {
        logic [2:0]        op;
        logic [IdW-1:0]    peer;
        logic [StampW-1:0] stamp;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  data;
    } t_op_xfer;

    typedef struct packed {
        logic [2:0]        kind;
        logic [IdW-1:0]    dest;
        logic [StampW-1:0] out_stamp;
        logic [1:0]        node_state;
        logic              last;
    } t_result;

endpackage

// File: rtl/mxn_in_if.sv
// Input event channel of the mutual exclusion node.
interface mxn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  peer_id;
    logic [15:0] stamp;

    modport source (output valid, output mode, output peer_id, output stamp, input ready);
    modport sink (input valid, input mode, input peer_id, input stamp, output ready);
endinterface

// File: rtl/mxn_out_if.sv
// Result channel of the mutual exclusion node.
interface mxn_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  dest;
    logic [15:0] out_stamp;
    logic [1:0]  node_state;
    logic        last;

    modport source (output valid, output kind, output dest, output out_stamp,
                    output node_state, output last, input ready);
    modport sink (input valid, input kind, input dest, input out_stamp,
                  input node_state, input last, output ready);
endinterface

// File: rtl/mxn_front.sv
// Front end: accept events and classify them into operations.
module mxn_front #(
    parameter int NODES = 16
) (
    input  logic [mxn_pkg::IdW-1:0] i_own_id,
    mxn_in_if.sink                  i_in,
    output mxn_pkg::t_op_xfer       o_push,
    input  logic                    i_push_ready
);

    logic bad_peer;

    assign bad_peer     = (i_in.peer_id == i_own_id) || (int'(i_in.peer_id) >= NODES);
    assign i_in.ready   = i_push_ready;
    assign o_push.valid = i_in.valid;

    always_comb begin
        o_push.data.peer  = i_in.peer_id;
        o_push.data.stamp = i_in.stamp;
        unique case (i_in.mode)
            mxn_pkg::M_LREQ:   o_push.data.op = mxn_pkg::OP_LREQ;
            mxn_pkg::M_LEXIT:  o_push.data.op = mxn_pkg::OP_LEXIT;
            mxn_pkg::M_RREQ:   o_push.data.op = bad_peer ? mxn_pkg::OP_BAD : mxn_pkg::OP_RREQ;
            mxn_pkg::M_RGRANT: o_push.data.op = bad_peer ? mxn_pkg::OP_BAD : mxn_pkg::OP_RGRANT;
            default:           o_push.data.op = mxn_pkg::OP_BAD;
        endcase
    end

endmodule

// File: rtl/mxn_queue.sv
// Two-entry operation queue between front and back.
module mxn_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mxn_pkg::t_op_xfer i_push,
    output logic              o_push_ready,
    output mxn_pkg::t_op_xfer o_pop,
    input  logic              i_pop_ready
);

    mxn_pkg::t_op r_slot [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         push_fire;
    logic         pop_fire;

    assign o_push_ready = (r_cnt != 2'd2);
    assign push_fire    = i_push.valid && o_push_ready;
    assign o_pop.valid  = (r_cnt != 2'd0);
    assign o_pop.data   = r_slot[r_rd];
    assign pop_fire     = o_pop.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_slot[r_wr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_fire) begin
                r_wr <= ~r_wr;
            end
            if (pop_fire) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push_fire} - {1'b0, pop_fire};
        end
    end

endmodule

// File: rtl/mxn_back.sv
// Back end: protocol state, deferred-peer memory and result register.
module mxn_back #(
    parameter int NODES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [mxn_pkg::IdW-1:0] i_own_id,
    input  mxn_pkg::t_op_xfer       i_pop,
    output logic                    o_pop_ready,
    mxn_out_if.source               o_out
);

    localparam int GcW = (NODES > 2) ? $clog2(NODES) : 1;
    localparam logic [GcW-1:0] GcMax = GcW'(NODES - 1);

    localparam logic S_EXEC  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic                         r_state, n_state;
    logic [1:0]                   r_phase, n_phase;
    logic [mxn_pkg::StampW-1:0]   r_req_stamp, n_req_stamp;
    logic [GcW-1:0]               r_gc, n_gc;
    logic [mxn_pkg::PtrW-1:0]     r_head, n_head;
    logic [mxn_pkg::FillW-1:0]    r_fill, n_fill;
    mxn_pkg::t_result             r_out, n_out;
    logic                         r_out_valid, n_out_valid;

    logic [mxn_pkg::IdW-1:0]      r_mem [mxn_pkg::FifoDepth];
    logic [mxn_pkg::IdW-1:0]      r_rd_data;
    logic                         w_en;
    logic [mxn_pkg::PtrW-1:0]     w_addr;
    logic                         out_free;
    logic                         peer_older;
    logic [GcW-1:0]               gc_inc;
    mxn_pkg::t_op                 op;

    assign op         = i_pop.data;
    assign out_free   = !r_out_valid || o_out.ready;
    assign peer_older = (op.stamp < r_req_stamp) ||
                        ((op.stamp == r_req_stamp) && (op.peer < i_own_id));
    assign gc_inc     = (r_gc < GcMax) ? (r_gc + GcW'(1)) : r_gc;
    assign w_addr     = r_head + r_fill[mxn_pkg::PtrW-1:0];

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out.kind;
    assign o_out.dest       = r_out.dest;
    assign o_out.out_stamp  = r_out.out_stamp;
    assign o_out.node_state = r_out.node_state;
    assign o_out.last       = r_out.last;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_req_stamp = r_req_stamp;
        n_gc        = r_gc;
        n_head      = r_head;
        n_fill      = r_fill;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        o_pop_ready = 1'b0;
        w_en        = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                if (i_pop.valid && out_free) begin
                    o_pop_ready     = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out.kind      = mxn_pkg::K_STATUS;
                    n_out.dest      = '0;
                    n_out.out_stamp = '0;
                    n_out.last      = 1'b1;
                    unique case (op.op)
                        mxn_pkg::OP_LREQ: begin
                            if (r_phase == mxn_pkg::PH_IDLE) begin
                                n_phase         = mxn_pkg::PH_WAIT;
                                n_req_stamp     = op.stamp;
                                n_gc            = '0;
                                n_out.kind      = mxn_pkg::K_BCAST;
                                n_out.out_stamp = op.stamp;
                            end else begin
                                n_out.kind = mxn_pkg::K_REJECT;
                            end
                        end
                        mxn_pkg::OP_LEXIT: begin
                            if (r_phase == mxn_pkg::PH_CS) begin
                                n_phase = mxn_pkg::PH_IDLE;
                                if (r_fill != '0) begin
                                    n_out_valid = 1'b0;
                                    n_state     = S_DRAIN;
                                end
                            end else begin
                                n_out.kind = mxn_pkg::K_REJECT;
                            end
                        end
                        mxn_pkg::OP_RREQ: begin
                            if ((r_phase == mxn_pkg::PH_IDLE) ||
                                ((r_phase == mxn_pkg::PH_WAIT) && peer_older)) begin
                                n_out.kind = mxn_pkg::K_GRANT;
                                n_out.dest = op.peer;
                            end else if (r_fill >= mxn_pkg::FillW'(mxn_pkg::FifoCap)) begin
                                n_out.kind = mxn_pkg::K_DROP;
                                n_out.dest = op.peer;
                            end else begin
                                w_en   = 1'b1;
                                n_fill = r_fill + mxn_pkg::FillW'(1);
                            end
                        end
                        mxn_pkg::OP_RGRANT: begin
                            if (r_phase == mxn_pkg::PH_WAIT) begin
                                if (gc_inc >= GcMax) begin
                                    n_gc       = '0;
                                    n_phase    = mxn_pkg::PH_CS;
                                    n_out.kind = mxn_pkg::K_ENTER;
                                end else begin
                                    n_gc = gc_inc;
                                end
                            end
                        end
                        default: begin
                            n_out.kind = mxn_pkg::K_REJECT;
                        end
                    endcase
                    n_out.node_state = n_phase;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.kind       = mxn_pkg::K_GRANT;
                    n_out.dest       = r_rd_data;
                    n_out.out_stamp  = '0;
                    n_out.node_state = r_phase;
                    n_out.last       = (r_fill == mxn_pkg::FillW'(1));
                    n_fill           = r_fill - mxn_pkg::FillW'(1);
                    if (r_fill == mxn_pkg::FillW'(1)) begin
                        n_head  = '0;
                        n_state = S_EXEC;
                    end else begin
                        n_head = r_head + mxn_pkg::PtrW'(1);
                    end
                end
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= op.peer;
        end
        r_rd_data <= r_mem[n_head];
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_phase     <= mxn_pkg::PH_IDLE;
            r_req_stamp <= '0;
            r_gc        <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_req_stamp <= n_req_stamp;
            r_gc        <= n_gc;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= mxn_pkg::FillW'(mxn_pkg::FifoCap))
        else $error("deferred fill above capacity");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_fill != '0) && (r_phase == mxn_pkg::PH_IDLE))
        else $error("drain with empty store or wrong phase");

    a_enter_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == mxn_pkg::K_ENTER)) |-> (r_phase == mxn_pkg::PH_CS))
        else $error("enter result without section phase");
`endif

endmodule

// File: rtl/mutual_exclusion_node.sv
// A result is valid once its event has passed the operation queue and the result register;
// one event per cycle goes through while the output is ready. An exit with N deferred peers
// holds the back end, one grant per cycle while ready, set by the memory's single read port.
// Results stay in an output register; the front keeps accepting while the queue has room.
// Reset (synchronous, active low) clears phase, request stamp, grant count, store pointers
// and own_id; the deferred-peer memory is not cleared and is read only where it was written.
module mutual_exclusion_node #(
    parameter int NODES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mxn_in_if.sink      i_in,
    mxn_out_if.source   o_out
);

    logic [mxn_pkg::IdW-1:0] r_own_id;
    mxn_pkg::t_op_xfer       push;
    mxn_pkg::t_op_xfer       pop;
    logic                    push_ready;
    logic                    pop_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, r_own_id} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_own_id <= pwdata[mxn_pkg::IdW-1:0];
        end
    end

    mxn_front #(.NODES(NODES)) u_front (
        .i_own_id     (r_own_id),
        .i_in         (i_in),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    mxn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_pop        (pop),
        .i_pop_ready  (pop_ready)
    );

    mxn_back #(.NODES(NODES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_own_id    (r_own_id),
        .i_pop       (pop),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule
